// ===== design/qri_pkg.sv =====
`default_nettype none

package qri_pkg;

    // Fixed field formats
    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int VEC_WIDTH      = 16;

    // Datapath widths derived from the formats
    localparam int P_W       = 2 * QUAT_WIDTH;
    localparam int T_W       = P_W + VEC_WIDTH;
    localparam int TERM_NUM  = 6;
    localparam int SUM_W     = T_W + 3;
    localparam int D_W       = ((SUM_W > 2 * QUAT_FRAC_BITS) ? SUM_W : 2 * QUAT_FRAC_BITS) + 1;
    localparam int SHIFT     = 2 * QUAT_FRAC_BITS - 1;
    localparam int RND_SHIFT = 2 * QUAT_FRAC_BITS - 2;
    localparam int Q_W       = D_W - SHIFT;
    localparam int DIFF_W    = ((Q_W > VEC_WIDTH) ? Q_W : VEC_WIDTH) + 1;

    typedef logic signed [QUAT_WIDTH-1:0] quat_t;
    typedef logic signed [VEC_WIDTH-1:0]  vec_t;
    typedef logic signed [P_W-1:0]        prod_t;

    // Per-stage load enables for the lane stages
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } qri_adv_t;

endpackage

`default_nettype wire

// ===== design/qri_lane.sv =====
`default_nettype none

module qri_lane (
    input  wire                         clk,
    input  qri_pkg::qri_adv_t           adv,
    input  qri_pkg::prod_t              prod [qri_pkg::TERM_NUM],
    input  qri_pkg::vec_t               vop  [qri_pkg::TERM_NUM],
    input  qri_pkg::vec_t               vin,
    output qri_pkg::vec_t               rot
);
    import qri_pkg::*;

    localparam logic signed [D_W-1:0] RND = {{(D_W-1){1'b0}}, 1'b1} << RND_SHIFT;

    logic signed [T_W-1:0]    term_reg [TERM_NUM];
    logic signed [T_W-1:0]    term_next [TERM_NUM];
    vec_t                     v2_reg;
    logic signed [D_W-1:0]    part_reg [3];
    logic signed [D_W-1:0]    part_next [3];
    vec_t                     v3_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [Q_W-1:0]    q_next;
    logic signed [D_W-1:0]    total;
    logic signed [D_W-1:0]    shifted;
    vec_t                     v4_reg;
    vec_t                     rot_reg;
    vec_t                     rot_next;
    logic signed [DIFF_W-1:0] diff;
    logic                     fits;

    // Stage 2: scale each quaternion pair product by its vector component
    always_comb
    begin
        for (int k = 0; k < TERM_NUM; k++)
        begin
            term_next[k] = prod[k] * vop[k];
        end
    end

    // Stage 3: fold six terms into three, subtract the cross term, add rounding
    always_comb
    begin
        part_next[0] = D_W'(term_reg[0]) - D_W'(term_reg[1]) + RND;
        part_next[1] = D_W'(term_reg[2]) + D_W'(term_reg[3]);
        part_next[2] = D_W'(term_reg[4]) + D_W'(term_reg[5]);
    end

    // Stage 4: final sum, drop the fraction (floor)
    always_comb
    begin
        total   = part_reg[0] + part_reg[1] + part_reg[2];
        shifted = total >>> SHIFT;
        q_next  = shifted[Q_W-1:0];
    end

    // Stage 5: remove the plain vector term and saturate
    always_comb
    begin
        diff = DIFF_W'(q_reg) - DIFF_W'(v4_reg);
        fits = (&diff[DIFF_W-1:VEC_WIDTH-1]) || !(|diff[DIFF_W-1:VEC_WIDTH-1]);
        if (fits)
        begin
            rot_next = diff[VEC_WIDTH-1:0];
        end
        else if (diff[DIFF_W-1])
        begin
            rot_next = {1'b1, {(VEC_WIDTH-1){1'b0}}};
        end
        else
        begin
            rot_next = {1'b0, {(VEC_WIDTH-1){1'b1}}};
        end
    end

    // Advance payload registers on their stage enables
    always_ff @(posedge clk)
    begin
        if (adv.en2)
        begin
            for (int k = 0; k < TERM_NUM; k++)
            begin
                term_reg[k] <= term_next[k];
            end
            v2_reg <= vin;
        end
        if (adv.en3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                part_reg[k] <= part_next[k];
            end
            v3_reg <= v2_reg;
        end
        if (adv.en4)
        begin
            q_reg  <= q_next;
            v4_reg <= v3_reg;
        end
        if (adv.en5)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

`default_nettype wire

// ===== design/quat_rotate_inverse_core.sv =====
// Throughput: one request per cycle while out_stall is low; the stages are quaternion pair
// products, vector scaling, partial sums with rounding, final sum with floor shift, and
// saturation. Each stage holds while the next is full and stalled; bubbles collapse.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is unreset.
`default_nettype none

module quat_rotate_inverse_core (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_stall,
    input  qri_pkg::quat_t quat_x,
    input  qri_pkg::quat_t quat_y,
    input  qri_pkg::quat_t quat_z,
    input  qri_pkg::quat_t quat_w,
    input  qri_pkg::vec_t  vec_x,
    input  qri_pkg::vec_t  vec_y,
    input  qri_pkg::vec_t  vec_z,
    output logic           out_valid,
    input  wire            out_stall,
    output qri_pkg::vec_t  rot_x,
    output qri_pkg::vec_t  rot_y,
    output qri_pkg::vec_t  rot_z
);
    import qri_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vld_next;
    logic [STAGES+1:1] ready;
    logic [STAGES:0]   vld_up;
    qri_adv_t          adv;

    prod_t ww_reg, wx_reg, wy_reg, wz_reg, xx_reg, xy_reg, xz_reg, yy_reg, yz_reg, zz_reg;
    prod_t ww_next, wx_next, wy_next, wz_next, xx_next, xy_next, xz_next;
    prod_t yy_next, yz_next, zz_next;
    vec_t  vx_reg, vy_reg, vz_reg;

    prod_t prod_x [TERM_NUM];
    prod_t prod_y [TERM_NUM];
    prod_t prod_z [TERM_NUM];
    vec_t  vop_x  [TERM_NUM];
    vec_t  vop_y  [TERM_NUM];
    vec_t  vop_z  [TERM_NUM];

    // Ready ripples back from the output; an empty stage always takes data
    always_comb
    begin
        ready[STAGES+1] = !out_stall;
        for (int i = STAGES; i >= 1; i--)
        begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
        vld_up = {vld_reg, in_valid};
        for (int i = 1; i <= STAGES; i++)
        begin
            vld_next[i] = ready[i] ? vld_up[i-1] : vld_reg[i];
        end
        adv.en2 = ready[2] && vld_reg[1];
        adv.en3 = ready[3] && vld_reg[2];
        adv.en4 = ready[4] && vld_reg[3];
        adv.en5 = ready[5] && vld_reg[4];
    end

    assign in_stall  = !ready[1];
    assign out_valid = vld_reg[STAGES];

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: all quaternion pair products
    always_comb
    begin
        ww_next = quat_w * quat_w;
        wx_next = quat_w * quat_x;
        wy_next = quat_w * quat_y;
        wz_next = quat_w * quat_z;
        xx_next = quat_x * quat_x;
        xy_next = quat_x * quat_y;
        xz_next = quat_x * quat_z;
        yy_next = quat_y * quat_y;
        yz_next = quat_y * quat_z;
        zz_next = quat_z * quat_z;
    end

    always_ff @(posedge clk)
    begin
        if (ready[1] && in_valid)
        begin
            ww_reg <= ww_next;
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            wz_reg <= wz_next;
            xx_reg <= xx_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yy_reg <= yy_next;
            yz_reg <= yz_next;
            zz_reg <= zz_next;
            vx_reg <= vec_x;
            vy_reg <= vec_y;
            vz_reg <= vec_z;
        end
    end

    // Route products and vector components to each lane; term 1 is subtracted
    always_comb
    begin
        prod_x = '{ww_reg, wy_reg, wz_reg, xx_reg, xy_reg, xz_reg};
        vop_x  = '{vx_reg, vz_reg, vy_reg, vx_reg, vy_reg, vz_reg};
        prod_y = '{ww_reg, wz_reg, wx_reg, xy_reg, yy_reg, yz_reg};
        vop_y  = '{vy_reg, vx_reg, vz_reg, vx_reg, vy_reg, vz_reg};
        prod_z = '{ww_reg, wx_reg, wy_reg, xz_reg, yz_reg, zz_reg};
        vop_z  = '{vz_reg, vy_reg, vx_reg, vx_reg, vy_reg, vz_reg};
    end

    qri_lane u_lane_x (
        .clk  (clk),
        .adv  (adv),
        .prod (prod_x),
        .vop  (vop_x),
        .vin  (vx_reg),
        .rot  (rot_x)
    );

    qri_lane u_lane_y (
        .clk  (clk),
        .adv  (adv),
        .prod (prod_y),
        .vop  (vop_y),
        .vin  (vy_reg),
        .rot  (rot_y)
    );

    qri_lane u_lane_z (
        .clk  (clk),
        .adv  (adv),
        .prod (prod_z),
        .vop  (vop_z),
        .vin  (vz_reg),
        .rot  (rot_z)
    );

    // A full pipeline behind a stalled output must stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&vld_reg) && out_stall) |-> in_stall)
        else $error("input not stalled with full pipeline");

    // An open output must never stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // An accepted request occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[1])
        else $error("accepted request lost at first stage");

endmodule

`default_nettype wire

// ===== tb/quat_rotate_inverse_core_tb.sv =====
module quat_rotate_inverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qri_pkg::*;

    localparam int QONE      = 1 << QUAT_FRAC_BITS;
    localparam int LONG_HOLD = 200;

    typedef struct {
        quat_t qx, qy, qz, qw;
        vec_t  vx, vy, vz;
    } quat_req_t;

    typedef struct {
        vec_t x, y, z;
    } rot_vec_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_stall = 1'b0;
    quat_t quat_x    = '0;
    quat_t quat_y    = '0;
    quat_t quat_z    = '0;
    quat_t quat_w    = '0;
    vec_t  vec_x     = '0;
    vec_t  vec_y     = '0;
    vec_t  vec_z     = '0;
    logic  in_stall;
    logic  out_valid;
    vec_t  rot_x;
    vec_t  rot_y;
    vec_t  rot_z;

    rot_vec_t expected_rot[$];
    int       error_count   = 0;
    int       request_count = 0;
    int       result_count  = 0;

    // Idling controls for the sender and the receiver
    bit sender_idle_on   = 1'b0;
    bit receiver_idle_on = 1'b0;
    int hold_ticket      = 0;
    int hold_seen        = 0;
    int hold_left        = 0;
    int burst_left       = 0;

    quat_rotate_inverse_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    always #5 clk = ~clk;

    // Round 2T at scale 2^(2F) to nearest (ties up), drop v, clamp to the vector range
    function automatic vec_t round_saturate(longint t, longint v);
        longint q;
        longint top;
        top = longint'(1) <<< (VEC_WIDTH - 1);
        q = ((t + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT) - v;
        if (q > top - 1)
            q = top - 1;
        else if (q < -top)
            q = -top;
        return vec_t'(q);
    endfunction

    // Inverse rotation: v*w^2 - w*(q x v) + q*(q . v), doubled and rescaled
    function automatic rot_vec_t predict_rotation(quat_req_t r);
        longint qx, qy, qz, w, vx, vy, vz, dot;
        rot_vec_t res;
        qx = r.qx;
        qy = r.qy;
        qz = r.qz;
        w  = r.qw;
        vx = r.vx;
        vy = r.vy;
        vz = r.vz;
        dot = qx * vx + qy * vy + qz * vz;
        res.x = round_saturate(w * w * vx - w * qy * vz + w * qz * vy + qx * dot, vx);
        res.y = round_saturate(w * w * vy - w * qz * vx + w * qx * vz + qy * dot, vy);
        res.z = round_saturate(w * w * vz - w * qx * vy + w * qy * vx + qz * dot, vz);
        return res;
    endfunction

    // Mix full-range values, corners and small magnitudes
    function automatic logic [15:0] rand_field();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 16'($urandom());
        if (pick < 8)
            return 16'($urandom_range(0, 512) - 256);
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            4:       return 16'hFFFF;
            5:       return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic quat_req_t pack_request(int qx, int qy, int qz, int qw,
                                               int vx, int vy, int vz);
        quat_req_t r;
        r.qx = quat_t'(qx);
        r.qy = quat_t'(qy);
        r.qz = quat_t'(qz);
        r.qw = quat_t'(qw);
        r.vx = vec_t'(vx);
        r.vy = vec_t'(vy);
        r.vz = vec_t'(vz);
        return r;
    endfunction

    // Half the requests carry a near-unit quaternion, the rest raw fields
    function automatic quat_req_t random_request();
        quat_req_t r;
        real a, b, c, d, n;
        r.vx = rand_field();
        r.vy = rand_field();
        r.vz = rand_field();
        if ($urandom_range(0, 1) == 0) begin
            a = real'($urandom_range(0, 65535)) - 32768.0;
            b = real'($urandom_range(0, 65535)) - 32768.0;
            c = real'($urandom_range(0, 65535)) - 32768.0;
            d = real'($urandom_range(0, 65535)) - 32768.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n == 0.0) begin
                d = 1.0;
                n = 1.0;
            end
            r.qx = quat_t'($rtoi(a / n * QONE));
            r.qy = quat_t'($rtoi(b / n * QONE));
            r.qz = quat_t'($rtoi(c / n * QONE));
            r.qw = quat_t'($rtoi(d / n * QONE));
        end
        else begin
            r.qx = rand_field();
            r.qy = rand_field();
            r.qz = rand_field();
            r.qw = rand_field();
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then log its expected rotation
    task automatic send_request(quat_req_t r);
        if (sender_idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x   <= r.qx;
        quat_y   <= r.qy;
        quat_z   <= r.qz;
        quat_w   <= r.qw;
        vec_x    <= r.vx;
        vec_y    <= r.vy;
        vec_z    <= r.vz;
        do
            @(posedge clk);
        while (in_stall);
        expected_rot.push_back(predict_rotation(r));
        request_count++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rot.size() != 0);
    endtask

    task automatic test_directed();
        sender_idle_on   <= 1'b0;
        receiver_idle_on <= 1'b0;
        // Identity quaternion with vector extremes
        send_request(pack_request(0, 0, 0, QONE, 32767, -32768, 0));
        send_request(pack_request(0, 0, 0, QONE, -32768, 32767, 1));
        // All-zero quaternion negates the vector, clamping at the top
        send_request(pack_request(0, 0, 0, 0, 1000, -1000, 32767));
        send_request(pack_request(0, 0, 0, 0, -32768, -32768, -32768));
        // Scalar part of -2.0, unnormalized
        send_request(pack_request(0, 0, 0, -32768, 1, -1, 100));
        send_request(pack_request(0, 0, 0, -32768, 32767, -32768, 5000));
        // Quaternion component extremes drive saturation
        send_request(pack_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
        send_request(pack_request(32767, 32767, 32767, 32767, -32768, -32768, -32768));
        send_request(pack_request(32767, 32767, 32767, 32767, 32767, 0, -32768));
        send_request(pack_request(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
        // Quarter turns about each axis and a half turn
        send_request(pack_request(11585, 0, 0, 11585, 0, 10000, 0));
        send_request(pack_request(0, 11585, 0, 11585, 0, 0, 10000));
        send_request(pack_request(0, 0, 11585, 11585, 10000, 0, 0));
        send_request(pack_request(QONE, 0, 0, 0, 100, 200, 300));
        // Exact rounding ties on both signs
        send_request(pack_request(0, 0, 0, 128, 4096, -4096, 12288));
        send_request(pack_request(0, 0, 0, 128, -12288, 20480, -20480));
        // Tiny values and alternating bit patterns
        send_request(pack_request(1, -1, 1, -1, 32767, 32767, 32767));
        send_request(pack_request(-1, -1, -1, -1, -1, -1, -1));
        send_request(pack_request(21845, -21846, 10922, -10923, 21845, -21846, 1));
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 700; i++) begin
            // Reshuffle idling every segment so some stretches run clean
            if (i % 100 == 0) begin
                sender_idle_on   <= ($urandom_range(0, 2) != 0);
                receiver_idle_on <= ($urandom_range(0, 2) != 0);
            end
            send_request(random_request());
        end
    endtask

    task automatic test_backpressure();
        sender_idle_on   <= 1'b0;
        receiver_idle_on <= 1'b0;
        hold_ticket      <= hold_ticket + 1;
        for (int i = 0; i < 80; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        sender_idle_on   <= 1'b1;
        receiver_idle_on <= 1'b1;
        for (int i = 0; i < 30; i++)
            send_request(random_request());
        wait_for_drain();
        for (int i = 0; i < 30; i++)
            send_request(random_request());
    endtask

    task automatic test_streaming();
        sender_idle_on   <= 1'b0;
        receiver_idle_on <= 1'b0;
        for (int i = 0; i < 440; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    // Receiver: long hold on request, otherwise random stall bursts
    always @(posedge clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            out_stall  <= 1'b1;
        end
        else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string axis, input vec_t want, input vec_t got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, axis, want, got);
        end
    endtask

    // Compare each accepted result against the oldest expectation
    always @(posedge clk) begin : check_results
        rot_vec_t want;
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            if (expected_rot.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result (%0d, %0d, %0d)", $time, rot_x, rot_y, rot_z);
            end
            else begin
                want = expected_rot.pop_front();
                check_field("rot_x", want.x, rot_x);
                check_field("rot_y", want.y, rot_y);
                check_field("rot_z", want.z, rot_z);
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix();
        test_backpressure();
        test_sender_pause();
        test_streaming();
        repeat (20) @(posedge clk);
        if (expected_rot.size() != 0) begin
            error_count += expected_rot.size();
            $display("%0t: %0d results never arrived", $time, expected_rot.size());
        end
        $display("%0d requests sent, %0d rotations checked, %0d errors", request_count,
                 result_count, error_count);
        $display("covered corners, rounding ties, saturation, long output hold and streaming");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_rot.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
